[rtl/core/shortest_queue_dispatcher_assert.svh]
// Assertion macros shared by the dispatcher RTL.
`ifndef SHORTEST_QUEUE_DISPATCHER_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCHER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define SQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define SQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");
`else
`define SQD_ASSERT_NOW(lbl, ante, cons)
`define SQD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/sqd_pkg.sv]
// Shared types and codes of the shortest queue dispatcher.
`timescale 1ns / 1ps
package sqd_pkg;

  localparam int WAIT_W = 16;
  localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_DONE    = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic MODE_FIRST_IDLE = 1'b0;
  localparam logic MODE_SHORTEST   = 1'b1;

  // Register select is byte address bit 2.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  localparam logic       MODE_RESET   = 1'b1;
  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } sqd_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } sqd_mem_ctl_t;

endpackage

[rtl/core/shortest_queue_dispatcher.sv]
// Top level of the join-shortest-queue dispatcher.
// Usage: commands arrive as words on the in_ stream. in_tuser is the command
// (0 arrival, 1 service done) and in_tdata[3:0] names the server for a done
// command. Every command yields exactly one word on the out_ stream carrying
// the assigned server, the status in out_tuser and the waiting count.
// Configuration (mode, active servers) goes through the APB-style cfg_ port
// and must only be written while no command is in flight.
// Sequence: an arrival is accepted, scans every server in use, passes the
// drain state and finishes; the occupancy memory is scanned one entry per
// cycle through its single read port. A done command makes one read and one
// write; a done command with a bad index goes straight to finish.
// A new command is taken only once the previous one has finished.
// Reset clears the occupancy counters through per-entry valid bits at once,
// zeroes the waiting count and restores mode 1 with 16 servers; no sweep is
// needed. If the receiver stalls, the finished word waits in the output
// register; the next command may still be accepted and scanned, and it
// stalls only at its final write until the output register is free.
`timescale 1ns / 1ps
`include "shortest_queue_dispatcher_assert.svh"
module shortest_queue_dispatcher
  import sqd_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [3:0] server_index, [7:4] zero
  input  logic [7:0]  in_tdata,
  // in_tuser: [0] cmd
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [3:0] assigned_server, [19:4] waiting_count, [23:20] zero
  output logic [23:0] out_tdata,
  // out_tuser: [1:0] status
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SRV_W = $clog2(MAX_SERVERS + 1);
  // Wide enough for the 5-bit register, the 4-bit index and the server count.
  localparam int NUM_W = (SRV_W > 5) ? SRV_W : 5;

  // Configuration registers.
  logic       mode_r;
  logic [4:0] active_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MODE:   mode_r   <= cfg_pwdata[0];
        REG_ACTIVE: active_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MODE:   cfg_prdata = {31'd0, mode_r};
      REG_ACTIVE: cfg_prdata = {27'd0, active_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Servers in use: zero counts as one, anything above the built size clamps.
  logic [NUM_W-1:0] act_ext;
  logic [NUM_W-1:0] n_now;

  assign act_ext = NUM_W'(active_r);
  assign n_now   = (act_ext == '0) ? NUM_W'(1) :
                   (act_ext > NUM_W'(MAX_SERVERS)) ? NUM_W'(MAX_SERVERS) : act_ext;

  // Sequencer state.
  sqd_state_t       state_r, state_nxt;
  logic             cmd_r;
  logic             bad_r;
  logic [IDX_W-1:0] idx_r;
  logic [NUM_W-1:0] job_n_r;
  logic             job_mode_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_vld_r;
  logic             cmp_first_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [COUNT_WIDTH-1:0] best_r;
  logic [IDX_W-1:0] pick_r;
  logic [WAIT_W-1:0] waiting_r, waiting_nxt;

  logic             in_fire;
  logic             in_bad;
  logic             scan_last;
  logic             fin_fire;
  logic [IDX_W-1:0] rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic             take_min;

  // Memory write side, driven only in the finish cycle.
  sqd_mem_ctl_t           mem_ctl;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [1:0]             fin_status;
  logic [3:0]             fin_assigned;

  // Output register.
  logic        out_valid_r;
  logic [3:0]  out_assigned_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_waiting_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_bad    = (in_tuser[0] == CMD_DONE) && (NUM_W'(in_tdata[3:0]) >= n_now);

  // An arrival walks every server in use; a done command reads its one entry.
  assign rd_addr   = (cmd_r == CMD_ARRIVAL) ? cnt_r : idx_r;
  assign scan_last = (cmd_r != CMD_ARRIVAL) || (NUM_W'(cnt_r) == job_n_r - NUM_W'(1));
  assign fin_fire  = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  // Read data is registered and so lags its address; strict compare keeps the lowest
  // index on a tie. The first entry seeds the running minimum.
  assign take_min = cmp_vld_r && (cmp_first_r || (rd_data < best_r));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = in_bad ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (fin_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result and write-back. In first-idle mode the minimum found is an idle
  // server exactly when that minimum is zero.
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = pick_r;
    wr_data      = best_r + COUNT_WIDTH'(1);
    fin_status   = ST_OK;
    fin_assigned = 4'd0;
    waiting_nxt  = waiting_r;
    if (fin_fire) begin
      if (bad_r) begin
        fin_status = ST_BAD;
      end else if (cmd_r == CMD_ARRIVAL) begin
        if ((job_mode_r == MODE_SHORTEST) || (best_r == '0)) begin
          fin_assigned = 4'(pick_r);
          wr_en        = (best_r != '1);
        end else begin
          fin_status = ST_WAIT;
          if (waiting_r != WAIT_MAX) begin
            waiting_nxt = waiting_r + WAIT_W'(1);
          end
        end
      end else begin
        wr_addr = idx_r;
        wr_data = best_r - COUNT_WIDTH'(1);
        wr_en   = (best_r != '0);
        if (waiting_r != '0) begin
          waiting_nxt = waiting_r - WAIT_W'(1);
        end
      end
    end
  end

  assign mem_ctl.rd_en = (state_r == S_SCAN);
  assign mem_ctl.wr_en = wr_en;

  sqd_occ_mem #(
    .DEPTH (MAX_SERVERS),
    .WIDTH (COUNT_WIDTH),
    .AW    (IDX_W)
  ) u_occ_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      waiting_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == S_SCAN);
      waiting_r <= waiting_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    cmp_idx_r <= rd_addr;
    if (in_fire) begin
      cmd_r       <= in_tuser[0];
      idx_r       <= IDX_W'(in_tdata[3:0]);
      bad_r       <= in_bad;
      job_n_r     <= n_now;
      job_mode_r  <= mode_r;
      cmp_first_r <= 1'b1;
    end else if (cmp_vld_r) begin
      cmp_first_r <= 1'b0;
    end
    if (take_min) begin
      best_r <= rd_data;
      pick_r <= cmp_idx_r;
    end
    if (fin_fire) begin
      out_assigned_r <= fin_assigned;
      out_status_r   <= fin_status;
      out_waiting_r  <= waiting_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_waiting_r, out_assigned_r};
  assign out_tuser  = out_status_r;

  // The scan pointer never leaves the servers in use.
  `SQD_ASSERT_NOW(a_scan_in_range, state_r == S_SCAN && cmd_r == CMD_ARRIVAL, NUM_W'(cnt_r) < job_n_r)
  // A finished command always lands in the output register and frees the block.
  `SQD_ASSERT_NEXT(a_finish_loads_out, fin_fire, out_tvalid && state_r == S_IDLE)
  // A waiting arrival or a bad index never names a server.
  `SQD_ASSERT_NOW(a_no_pick_on_fail, out_tvalid && out_tuser != ST_OK, out_tdata[3:0] == 4'd0)
  // A bad index leaves the occupancy memory untouched.
  `SQD_ASSERT_NOW(a_bad_no_write, state_r == S_FINISH && bad_r, !mem_ctl.wr_en)

endmodule

[rtl/core/sqd_occ_mem.sv]
// Occupancy counter memory with per-entry valid bits and registered read.
`timescale 1ns / 1ps
module sqd_occ_mem
  import sqd_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sqd_mem_ctl_t     ctl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule
